// ===== src/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the stuffed frame receiver
// Byte codes of the link protocol, parser states, reply kinds and the
// descriptor that passes from the parser to the reply serialiser.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam logic [7:0] FLAG_BYTE     = 8'h7E;
    localparam logic [7:0] ESC_BYTE      = 8'h7D;
    localparam logic [7:0] ESC_FLAG      = 8'h5E;
    localparam logic [7:0] ESC_ESC       = 8'h5D;
    localparam logic [7:0] CTRL_SET      = 8'h03;
    localparam logic [7:0] CTRL_UA       = 8'h07;
    localparam logic [7:0] CTRL_DATA0    = 8'h00;
    localparam logic [7:0] CTRL_DATA1    = 8'h80;
    localparam logic [7:0] CTRL_RR0      = 8'hAB;
    localparam logic [7:0] CTRL_RR1      = 8'hAA;
    localparam logic [7:0] CTRL_REJ0     = 8'h54;
    localparam logic [7:0] CTRL_REJ1     = 8'h55;

    localparam logic [7:0] RX_ADDR_RESET    = 8'h03;
    localparam logic [7:0] REPLY_ADDR_RESET = 8'h01;

    // Register indexes of the configuration port.
    localparam logic REG_RX_ADDR    = 1'b0;
    localparam logic REG_REPLY_ADDR = 1'b1;

    // Reply queue depth and the beat indexes of a reply frame.
    localparam int          QUEUE_DEPTH = 2;
    localparam logic [2:0]  BEAT_FLAG0  = 3'd0;
    localparam logic [2:0]  BEAT_ADDR   = 3'd1;
    localparam logic [2:0]  BEAT_CTRL   = 3'd2;
    localparam logic [2:0]  BEAT_BCC    = 3'd3;
    localparam logic [2:0]  BEAT_LAST   = 3'd4;

    typedef enum logic [2:0] {
        HS_HUNT = 3'd0,
        HS_FLAG = 3'd1,
        HS_ADDR = 3'd2,
        HS_CTRL = 3'd3,
        HS_BODY = 3'd4
    } t_hdr_state;

    typedef enum logic [1:0] {
        KIND_UA  = 2'd0,
        KIND_RR  = 2'd1,
        KIND_REJ = 2'd2
    } t_reply_kind;

    typedef struct packed {
        logic [7:0]  addr;
        logic [7:0]  ctrl;
        t_reply_kind kind;
    } t_reply;

endpackage

// ===== src/sfr_front.sv =====
// ----------------------------------------------------------------------------
// sfr_front: frame parser
// Matches SET and data frame headers, destuffs the payload, keeps the running
// check XOR and posts one reply descriptor per closing flag of a matched frame.
// ----------------------------------------------------------------------------
module sfr_front import sfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_rx_address,
    input  logic [7:0] i_reply_address,
    input  logic       i_full,
    output logic       o_push,
    output t_reply     o_entry
);

    t_hdr_state r_state, n_state;
    logic       r_phase, n_phase;
    logic       r_parity, n_parity;
    logic [7:0] r_xor, n_xor;
    logic       r_esc, n_esc;

    logic       accept;
    logic [7:0] ctrl;

    // The parser waits whenever the queue has no room for a reply.
    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign ctrl    = r_parity ? CTRL_DATA1 : CTRL_DATA0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= HS_HUNT;
            r_phase  <= 1'b0;
            r_parity <= 1'b0;
            r_xor    <= 8'h00;
            r_esc    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_parity <= n_parity;
            r_xor    <= n_xor;
            r_esc    <= n_esc;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_phase        = r_phase;
        n_parity       = r_parity;
        n_xor          = r_xor;
        n_esc          = r_esc;
        o_push         = 1'b0;
        o_entry.addr   = i_reply_address;
        o_entry.ctrl   = CTRL_UA;
        o_entry.kind   = KIND_UA;
        if (accept) begin
            unique case (r_state)
                HS_FLAG: begin
                    if (i_byte == i_rx_address) begin
                        n_state = HS_ADDR;
                    end else if (i_byte != FLAG_BYTE) begin
                        n_state = HS_HUNT;
                    end
                end
                HS_ADDR: begin
                    if (!r_phase && i_byte == CTRL_SET) begin
                        n_state = HS_CTRL;
                    end else if (r_phase && (i_byte == CTRL_DATA0 || i_byte == CTRL_DATA1)) begin
                        n_parity = (i_byte == CTRL_DATA1);
                        n_state  = HS_CTRL;
                    end else begin
                        n_state = (i_byte == FLAG_BYTE) ? HS_FLAG : HS_HUNT;
                    end
                end
                HS_CTRL: begin
                    if (!r_phase) begin
                        if (i_byte == (i_rx_address ^ CTRL_SET)) begin
                            n_state = HS_BODY;
                        end else begin
                            n_state = (i_byte == FLAG_BYTE) ? HS_FLAG : HS_HUNT;
                        end
                    end else begin
                        if (i_byte == (i_rx_address ^ ctrl)) begin
                            n_state = HS_BODY;
                            n_xor   = 8'h00;
                            n_esc   = 1'b0;
                        end else begin
                            n_state = (i_byte == FLAG_BYTE) ? HS_FLAG : HS_HUNT;
                        end
                    end
                end
                HS_BODY: begin
                    if (!r_phase) begin
                        // A SET frame must close right after its header check.
                        n_state = HS_HUNT;
                        if (i_byte == FLAG_BYTE) begin
                            n_phase = 1'b1;
                            o_push  = 1'b1;
                        end
                    end else if (i_byte == FLAG_BYTE) begin
                        n_state = HS_HUNT;
                        n_xor   = 8'h00;
                        n_esc   = 1'b0;
                        o_push  = 1'b1;
                        if (r_xor == 8'h00) begin
                            o_entry.kind = KIND_RR;
                            o_entry.ctrl = r_parity ? CTRL_RR1 : CTRL_RR0;
                        end else begin
                            o_entry.kind = KIND_REJ;
                            o_entry.ctrl = r_parity ? CTRL_REJ1 : CTRL_REJ0;
                        end
                    end else if (r_esc) begin
                        // Unknown escape sequences are dropped.
                        n_esc = 1'b0;
                        if (i_byte == ESC_FLAG) begin
                            n_xor = r_xor ^ FLAG_BYTE;
                        end else if (i_byte == ESC_ESC) begin
                            n_xor = r_xor ^ ESC_BYTE;
                        end
                    end else if (i_byte == ESC_BYTE) begin
                        n_esc = 1'b1;
                    end else begin
                        n_xor = r_xor ^ i_byte;
                    end
                end
                default: begin
                    n_state = (i_byte == FLAG_BYTE) ? HS_FLAG : HS_HUNT;
                end
            endcase
        end
    end

endmodule

// ===== src/sfr_queue.sv =====
// ----------------------------------------------------------------------------
// sfr_queue: reply descriptor queue
// A two-entry first-in first-out store between parser and serialiser.
// ----------------------------------------------------------------------------
module sfr_queue import sfr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_reply i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_reply o_entry
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_reply          r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("reply pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("reply popped from an empty queue");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill level did not follow a push");

endmodule

// ===== src/sfr_back.sv =====
// ----------------------------------------------------------------------------
// sfr_back: reply serialiser
// Turns each reply descriptor into the five beats of a reply frame.
// ----------------------------------------------------------------------------
module sfr_back import sfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_reply      i_entry,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_tx_byte,
    output logic [1:0]  o_reply_kind,
    output logic        o_last_byte
);

    logic       r_busy, n_busy;
    logic [2:0] r_idx, n_idx;
    t_reply     r_cur, n_cur;
    logic       done;

    // The current frame is finished when its closing flag beat is taken.
    assign done  = r_busy && !i_stall && (r_idx == BEAT_LAST);
    assign o_pop = !i_empty && (!r_busy || done);

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_cur  = r_cur;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = BEAT_FLAG0;
            n_cur  = i_entry;
        end else if (done) begin
            n_busy = 1'b0;
        end else if (r_busy && !i_stall) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= BEAT_FLAG0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    always_comb begin
        case (r_idx)
            BEAT_ADDR: o_tx_byte = r_cur.addr;
            BEAT_CTRL: o_tx_byte = r_cur.ctrl;
            BEAT_BCC:  o_tx_byte = r_cur.addr ^ r_cur.ctrl;
            default:   o_tx_byte = FLAG_BYTE;
        endcase
    end

    assign o_valid      = r_busy;
    assign o_reply_kind = r_cur.kind;
    assign o_last_byte  = (r_idx == BEAT_LAST);

endmodule

// ===== src/stuffed_frame_receiver_with_ack.sv =====
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_with_ack: byte-stuffed frame receiver with replies
// Parses SET and data frames from a received byte stream and answers a good
// SET in the setup phase with UA and each later data frame with RR or REJ.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                Payload
//  rx        in         i_rx_valid / o_rx_stall  i_rx_byte
//  tx        out        o_tx_valid / i_tx_stall  o_tx_byte, o_reply_kind, o_last_byte
//  config    in         APB write/read           rx_address @0, reply_address @4
//
//  The parser takes one received beat every cycle while rx is not stalled; a
//  beat leaves its effect in the frame state by the next edge. A closing flag
//  posts one descriptor into a two-entry queue and the serialiser sends its
//  five beats one per cycle while tx is not stalled, from its registered copy
//  of the queue head. The rx side stalls only while the queue is full, that is
//  while replies arrive faster than the tx side takes their beats. Reset is
//  synchronous and returns the link to the setup phase, hunting for an opening
//  flag, address registers at defaults (3 and 1); no clearing pass.
//
module stuffed_frame_receiver_with_ack import sfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_tx_valid,
    input  logic        i_tx_stall,
    output logic [7:0]  o_tx_byte,
    output logic [1:0]  o_reply_kind,
    output logic        o_last_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_rx_address;
    logic [7:0] r_reply_address;
    logic       cfg_write;
    logic       q_push, q_pop, q_full, q_empty;
    t_reply     q_in, q_out;

    // Registers sit at word addresses; only the word select bit decodes.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_address    <= RX_ADDR_RESET;
            r_reply_address <= REPLY_ADDR_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_RX_ADDR) begin
                r_rx_address <= pwdata[7:0];
            end else begin
                r_reply_address <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_RX_ADDR) begin
            prdata = {24'h000000, r_rx_address};
        end else begin
            prdata = {24'h000000, r_reply_address};
        end
    end

    // Front end: header matching, destuffing and check accumulation.
    sfr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_rx_valid),
        .o_stall         (o_rx_stall),
        .i_byte          (i_rx_byte),
        .i_rx_address    (r_rx_address),
        .i_reply_address (r_reply_address),
        .i_full          (q_full),
        .o_push          (q_push),
        .o_entry         (q_in)
    );

    // The queue lets the parser run on while a reply is still going out.
    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_entry (q_out)
    );

    // Back end: one reply frame beat per cycle while tx is not stalled.
    sfr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_entry      (q_out),
        .o_pop        (q_pop),
        .o_valid      (o_tx_valid),
        .i_stall      (i_tx_stall),
        .o_tx_byte    (o_tx_byte),
        .o_reply_kind (o_reply_kind),
        .o_last_byte  (o_last_byte)
    );

endmodule
